// File: hw/rtl/asmm_pkg.sv
package asmm_pkg;

  localparam int unsigned CLASS_W = 2;
  localparam int unsigned TYPE_W  = 6;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned DATA_W  = 2 * HALF_W;
  localparam int unsigned NBYTES  = DATA_W / 8;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned IN_TDATA_W  = CLASS_W + TYPE_W + MASK_W + 2 * HALF_W;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = HALF_W;

  // type codes with a rule of their own
  localparam logic [TYPE_W-1:0] TYPE_IPV4   = 6'd21;
  localparam logic [TYPE_W-1:0] TYPE_DECNET = 6'd22;
  localparam logic [TYPE_W-1:0] TYPE_IPV6   = 6'd24;

  // ipv6 prefix length that covers the whole address
  localparam logic [15:0] IPV6_FULL_PFX = 16'd128;

  // decnet area/node selector codes in the upper mask half
  localparam logic [15:0] DEC_SEL_BOTH = 16'hC000;
  localparam logic [15:0] DEC_SEL_NODE = 16'h8000;
  localparam logic [15:0] DEC_SEL_AREA = 16'h4000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LO = 3'd4;

  typedef struct packed {
    logic [HALF_W-1:0]  data_low;
    logic [HALF_W-1:0]  data_high;
    logic [MASK_W-1:0]  mask;
    logic [TYPE_W-1:0]  spec_type;
    logic [CLASS_W-1:0] spec_class;
  } spec_t;

  // compare length in bytes per type code
  function automatic logic [LEN_W-1:0] type_len(input logic [TYPE_W-1:0] t);
    logic [LEN_W-1:0] len;
    unique case (t)
      6'd1:  len = 5'd2;
      6'd2:  len = 5'd1;
      6'd3:  len = 5'd5;
      6'd4:  len = 5'd1;
      6'd5:  len = 5'd1;
      6'd6:  len = 5'd1;
      6'd8:  len = 5'd8;
      6'd9:  len = 5'd4;
      6'd10: len = 5'd6;
      6'd11: len = 5'd6;
      6'd12: len = 5'd6;
      6'd13: len = 5'd6;
      6'd20: len = 5'd3;
      6'd21: len = 5'd4;
      6'd22: len = 5'd2;
      6'd24: len = 5'd16;
      6'd25: len = 5'd10;
      6'd32: len = 5'd1;
      6'd33: len = 5'd1;
      6'd34: len = 5'd2;
      6'd35: len = 5'd2;
      6'd36: len = 5'd4;
      6'd37: len = 5'd2;
      6'd38: len = 5'd2;
      6'd43: len = 5'd2;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/asmm_match.sv
module asmm_match import asmm_pkg::*; (
  input  spec_t item,
  input  spec_t filt,
  output logic  is_match
);

  logic [DATA_W-1:0] dat_i;
  logic [DATA_W-1:0] dat_f;
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] pfx_mask;
  logic [MASK_W-1:0] both;
  logic [15:0]       p1;
  logic [15:0]       p2;
  logic [15:0]       pfx;
  logic              pfx_any;
  logic [15:0]       dec_sel;
  logic [7:0]        dec_m0;
  logic [7:0]        dec_m1;
  logic [LEN_W-1:0]  len;
  logic [NBYTES-1:0] byte_ne;
  logic [NBYTES-1:0] byte_chk;
  logic              hit_ip4;
  logic              hit_ip6;
  logic              hit_dec;
  logic              hit_byte;

  assign dat_i = {item.data_high, item.data_low};
  assign dat_f = {filt.data_high, filt.data_low};
  assign diff  = dat_i ^ dat_f;
  assign both  = item.mask & filt.mask;

  // ipv4: bit mask over the first four bytes
  assign hit_ip4 = ((diff[DATA_W-1 -: MASK_W] & both) == '0);

  // ipv6: longer of the two prefixes, msb first
  assign p1      = item.mask[15:0];
  assign p2      = filt.mask[15:0];
  assign pfx     = (p1 > p2) ? p1 : p2;
  assign pfx_any = (p1 != '0) || (p2 != '0);
  assign pfx_mask = (pfx >= IPV6_FULL_PFX) ? {DATA_W{1'b1}}
                                           : ~({DATA_W{1'b1}} >> pfx[6:0]);
  assign hit_ip6 = ((diff & pfx_mask) == '0);

  // decnet: byte masks from the upper mask half
  assign dec_sel = filt.mask[31:16] & item.mask[31:16];
  always_comb begin
    unique case (dec_sel)
      DEC_SEL_BOTH: begin
        dec_m0 = 8'hFF;
        dec_m1 = 8'hFF;
      end
      DEC_SEL_NODE: begin
        dec_m0 = 8'h00;
        dec_m1 = 8'hFC;
      end
      DEC_SEL_AREA: begin
        dec_m0 = 8'hFF;
        dec_m1 = 8'h03;
      end
      default: begin
        dec_m0 = 8'h00;
        dec_m1 = 8'h00;
      end
    endcase
  end
  assign hit_dec = ((diff[DATA_W-1 -: 8] & dec_m0) == '0) &&
                   ((diff[DATA_W-9 -: 8] & dec_m1) == '0);

  // per-byte rule, byte k selected by mask bit 31-k in both masks
  assign len = type_len(item.spec_type);
  always_comb begin
    for (int k = 0; k < NBYTES; k++) begin
      byte_ne[k]  = (diff[DATA_W-1-8*k -: 8] != '0);
      byte_chk[k] = (LEN_W'(k) < len) && both[MASK_W-1-k];
    end
  end
  assign hit_byte = ((byte_ne & byte_chk) == '0);

  always_comb begin
    priority if ((item.spec_class != filt.spec_class) ||
                 (item.spec_type != filt.spec_type)) begin
      is_match = 1'b0;
    end else if (item.spec_type == TYPE_IPV4) begin
      is_match = hit_ip4;
    end else if ((item.spec_type == TYPE_IPV6) && pfx_any) begin
      is_match = hit_ip6;
    end else if (item.spec_type == TYPE_DECNET) begin
      is_match = hit_dec;
    end else begin
      is_match = hit_byte;
    end
  end

endmodule

// File: hw/rtl/address_spec_masked_match_unit.sv
// masked address/protocol spec filter, one compare per word
//
// input channel: in_tvalid/in_tready/in_tdata carries one spec word (class,
// type, mask and 16 data bytes). the user loads the configured filter spec via
// cfg_we/cfg_index/cfg_wdata while the block is idle, which is not enforced.
// result channel: out_tvalid/out_tready/out_tdata carries one word per input
// word, bit 0 is the match flag.
//
// timing: the accepted word goes into the input register, then through the
// compare logic into the result register, which drives out_tvalid.
// throughput: one word per cycle while the receiver takes results, set by
// the two-stage register pipeline with a single-pass compare.
// when the receiver stalls, the result register holds and the input register
// may still take one more word; in_tready drops only when both are full and
// out_tready is low.
// reset (rst_n low, synchronous) empties both stages and clears the filter
// spec to all zeros.
module address_spec_masked_match_unit import asmm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: item_class[1:0], item_type[7:2], item_mask[39:8],
  //           item_data_high[103:40], item_data_low[167:104]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: is_match[0], zeros above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  spec_t filt_r;
  spec_t filt_nxt;
  spec_t s1_spec_r;
  logic  s1_v_r;
  logic  s1_v_nxt;
  logic  out_v_r;
  logic  out_v_nxt;
  logic  out_match_r;
  logic  match;
  logic  advance;
  logic  in_acc;

  // pipeline moves when the result register is free or being taken
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // filter spec registers
  always_comb begin
    filt_nxt = filt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLASS:   filt_nxt.spec_class = cfg_wdata[CLASS_W-1:0];
        CFG_TYPE:    filt_nxt.spec_type  = cfg_wdata[TYPE_W-1:0];
        CFG_MASK:    filt_nxt.mask       = cfg_wdata[MASK_W-1:0];
        CFG_DATA_HI: filt_nxt.data_high  = cfg_wdata;
        CFG_DATA_LO: filt_nxt.data_low   = cfg_wdata;
        default:     filt_nxt = filt_r; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else begin
      filt_r <= filt_nxt;
    end
  end

  // stage valids
  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_v_r);
    out_v_nxt = advance ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input register, unpacked from the stream word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_spec_r <= spec_t'(in_tdata);
    end
  end

  asmm_match u_match (
    .item     (s1_spec_r),
    .filt     (filt_r),
    .is_match (match)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      out_match_r <= match;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_match_r};

endmodule

// File: hw/rtl/asmm_checker.sv
module asmm_checker import asmm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an accepted word moves on to out_tvalid when the receiver keeps taking
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after accept");

  // padding bits of the result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("nonzero padding in result word");

endmodule

bind address_spec_masked_match_unit asmm_checker u_asmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
